@@ rtl/m4ma_pkg.sv @@
package m4ma_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_LOAD_ACC = 2'd0,
    CMD_LOAD_OP  = 2'd1,
    CMD_MULTIPLY = 2'd2,
    CMD_IDENTITY = 2'd3
  } cmd_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    cmd_e               command;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic               result_last;
  } out_item_t;

endpackage

@@ rtl/m4ma_chan_if.sv @@
interface m4ma_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/m4ma_ram.sv @@
module m4ma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/m4ma_fifo.sv @@
module m4ma_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  m4ma_pkg::in_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output m4ma_pkg::in_item_t pop_data_o,
  output logic               empty_o
);
  import m4ma_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  in_item_t        slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end
endmodule

@@ rtl/m4ma_front.sv @@
module m4ma_front #(
  parameter int DIM = 4
) (
  m4ma_chan_if.sink          in_i,
  input  logic               full_i,
  output logic               push_o,
  output m4ma_pkg::in_item_t push_data_o
);
  import m4ma_pkg::*;

  localparam logic [7:0] CellCount = 8'(DIM * DIM);

  logic is_load;
  logic in_range;

  // loads outside the matrix are accepted and dropped here
  assign is_load  = (in_i.data.command == CMD_LOAD_ACC) || (in_i.data.command == CMD_LOAD_OP);
  assign in_range = ({4'b0, in_i.data.element_index} < CellCount);

  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i && (!is_load || in_range);
  assign push_data_o = in_i.data;
endmodule

@@ rtl/m4ma_back.sv @@
module m4ma_back #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_vld_i,
  input  m4ma_pkg::in_item_t head_i,
  output logic               pop_o,
  m4ma_chan_if.source        out_o
);
  import m4ma_pkg::*;

  localparam int Cells = DIM * DIM;
  localparam int CellW = $clog2(Cells);
  localparam int DimW  = $clog2(DIM);
  localparam int SumW  = 64 + $clog2(DIM);
  localparam logic signed [31:0] FixOne = 32'sd1 <<< FRAC_BITS;

  bk_state_e state_q, state_d;
  logic [DimW-1:0] r_q, r_d, c_q, c_d, e_q, e_d;
  logic            bank_q;
  logic [Cells-1:0] acc_vld_q [2];
  logic [Cells-1:0] op_vld_q;

  // control strobes
  logic issue, emit_fire, last_elem;
  logic do_load_acc, do_load_op, do_identity;

  // addresses
  logic [CellW-1:0] acc_rcell, op_rcell, k_cell, head_cell;

  // pipeline
  logic                s1_vld_q, s1_first_q, s1_last_q, s1_avld_q, s1_adiag_q, s1_ovld_q;
  logic                s2_vld_q, s2_first_q, s2_last_q;
  logic                sum_done_q;
  logic signed [63:0]  p_q;
  logic signed [SumW-1:0] sum_q, shifted;
  logic [SumW-32:0]    sum_hi;
  logic signed [31:0]  a_val, o_val, sat_val;
  logic [31:0]         acc_rdata, op_rdata;

  // memory ports
  logic             acc_we;
  logic [CellW:0]   acc_waddr;
  logic [31:0]      acc_wdata;

  // output register
  logic      out_vld_q;
  out_item_t out_q;
  logic      slot_free;

  assign head_cell = CellW'(head_i.element_index);
  assign acc_rcell = CellW'(r_q) + CellW'(DIM) * CellW'(e_q);
  assign op_rcell  = CellW'(e_q) + CellW'(DIM) * CellW'(c_q);
  assign k_cell    = CellW'(r_q) + CellW'(DIM) * CellW'(c_q);
  assign last_elem = (k_cell == CellW'(Cells - 1));
  assign slot_free = !out_vld_q || out_o.ready;

  // sequencer: next state and strobes
  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    c_d         = c_q;
    e_d         = e_q;
    issue       = 1'b0;
    emit_fire   = 1'b0;
    do_load_acc = 1'b0;
    do_load_op  = 1'b0;
    do_identity = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (head_vld_i) begin
          case (head_i.command)
            CMD_LOAD_ACC: begin
              do_load_acc = 1'b1;
              pop_o       = 1'b1;
            end
            CMD_LOAD_OP: begin
              do_load_op = 1'b1;
              pop_o      = 1'b1;
            end
            CMD_IDENTITY: begin
              do_identity = 1'b1;
              pop_o       = 1'b1;
            end
            CMD_MULTIPLY: begin
              r_d     = '0;
              c_d     = '0;
              e_d     = '0;
              state_d = BK_MAC;
            end
            default: ;
          endcase
        end
      end
      BK_MAC: begin
        issue = 1'b1;
        if (e_q == DimW'(DIM - 1)) begin
          e_d     = '0;
          state_d = BK_DRAIN;
        end else begin
          e_d = e_q + 1'b1;
        end
      end
      BK_DRAIN: begin
        if (sum_done_q) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          emit_fire = 1'b1;
          if (last_elem) begin
            pop_o   = 1'b1;
            state_d = BK_IDLE;
          end else begin
            state_d = BK_MAC;
            if (r_q == DimW'(DIM - 1)) begin
              r_d = '0;
              c_d = c_q + 1'b1;
            end else begin
              r_d = r_q + 1'b1;
            end
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      e_q     <= e_d;
    end
  end

  // bank select and per-entry written flags; an unwritten entry reads as its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q       <= 1'b0;
      acc_vld_q[0] <= '0;
      acc_vld_q[1] <= '0;
      op_vld_q     <= '0;
    end else begin
      if (do_load_acc) begin
        acc_vld_q[bank_q][head_cell] <= 1'b1;
      end
      if (do_identity) begin
        acc_vld_q[bank_q] <= '0;
      end
      if (do_load_op) begin
        op_vld_q[head_cell] <= 1'b1;
      end
      if (emit_fire) begin
        acc_vld_q[~bank_q][k_cell] <= 1'b1;
        if (last_elem) begin
          bank_q <= ~bank_q;
        end
      end
    end
  end

  // accumulated matrix, two banks: read current, product goes to the other
  assign acc_we    = do_load_acc || emit_fire;
  assign acc_waddr = emit_fire ? {~bank_q, k_cell} : {bank_q, head_cell};
  assign acc_wdata = emit_fire ? sat_val : head_i.element_value;

  m4ma_ram #(
    .WIDTH(32),
    .DEPTH(2 << CellW)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (acc_we),
    .waddr_i(acc_waddr),
    .wdata_i(acc_wdata),
    .re_i   (issue),
    .raddr_i({bank_q, acc_rcell}),
    .rdata_o(acc_rdata)
  );

  m4ma_ram #(
    .WIDTH(32),
    .DEPTH(Cells)
  ) u_op_ram (
    .clk_i  (clk_i),
    .we_i   (do_load_op),
    .waddr_i(head_cell),
    .wdata_i(head_i.element_value),
    .re_i   (issue),
    .raddr_i(op_rcell),
    .rdata_o(op_rdata)
  );

  // stage 1: read flags travel with the registered memory data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_first_q <= (e_q == '0);
      s1_last_q  <= (e_q == DimW'(DIM - 1));
      s1_avld_q  <= acc_vld_q[bank_q][acc_rcell];
      s1_adiag_q <= (r_q == e_q);
      s1_ovld_q  <= op_vld_q[op_rcell];
    end
  end

  // stage 2: one product
  always_comb begin
    a_val = s1_avld_q ? $signed(acc_rdata) : (s1_adiag_q ? FixOne : 32'sd0);
    o_val = s1_ovld_q ? $signed(op_rdata) : 32'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      p_q        <= a_val * o_val;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // stage 3: exact wide sum of the products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_done_q <= 1'b0;
    end else begin
      sum_done_q <= s2_vld_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      sum_q <= s2_first_q ? SumW'(p_q) : sum_q + SumW'(p_q);
    end
  end

  // floor shift and saturate to 32 bits
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    sum_hi  = shifted[SumW-1:31];
    if (sum_hi == '0 || sum_hi == '1) begin
      sat_val = shifted[31:0];
    end else begin
      sat_val = shifted[SumW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.result_index <= 4'(k_cell);
      out_q.result_value <= sat_val;
      out_q.result_last  <= last_elem;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;
endmodule

@@ rtl/mat4_multiply_accumulate_unit.sv @@
// Loads and set-identity are applied by the back end when they reach the queue head while it is idle.
// A multiply is decoded, then each of the DIM*DIM product elements is formed in turn: DIM reads
// and MACs on the shared multiplier, a drain through the pipeline and one emit.
// Items are accepted while the command queue has room; output stalls hold the back end.
// Async active-low reset: accumulated matrix reads as identity, operand matrix as zero.
module mat4_multiply_accumulate_unit #(
  parameter int DIM         = 4,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  m4ma_chan_if.sink   in_i,
  m4ma_chan_if.source out_o
);
  import m4ma_pkg::*;

  logic     push, full, pop, empty;
  in_item_t push_data, head;

  m4ma_front #(
    .DIM(DIM)
  ) u_front (
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  m4ma_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (head),
    .empty_o    (empty)
  );

  m4ma_back #(
    .DIM      (DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_vld_i(!empty),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o)
  );
endmodule
